[src/csef_pkg.sv]
package csef_pkg;

	localparam int SPEED_WIDTH_DEF = 16;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int WEIGHT_W    = 17;
	localparam int LIMIT_W     = 15;
	localparam int FILT_W      = 32;

	localparam logic [WEIGHT_W-1:0] ONE_Q16       = 17'd65536;
	localparam logic [WEIGHT_W-1:0] RESET_WEIGHT  = 17'd22938;
	localparam logic [LIMIT_W-1:0]  DEFAULT_LIMIT = 15'd5000;

	localparam logic [CFG_INDEX_W-1:0] REG_USE_MAGNITUDE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT      = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SUM,
		ST_ROOT,
		ST_CLAMP,
		ST_DIFF,
		ST_MUL,
		ST_UPDATE,
		ST_WRITE
	} csef_state_t;

endpackage

[src/clamped_speed_ema_filter_unit.sv]
// channel  direction  handshake                  payload
// s_*      in         s_tvalid / s_tready        s_tdata: vel_x, vel_y
// m_*      out        m_tvalid / m_tready        m_tdata: smoothed_speed
// cfg_*    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// magnitude mode adds a pass through the square root unit, one root bit a cycle.
// the first sample after reset loads the filter and skips the update.
// one shared signed multiplier forms both squares and the weighted update.
// reset clears the registers to their defaults and the filter to unprimed.
// a stalled output holds the result; the next input is taken meanwhile.
module clamped_speed_ema_filter_unit
	#(
	parameter int SPEED_WIDTH = csef_pkg::SPEED_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vel_x, vel_y
	input  logic [((2*SPEED_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// smoothed_speed
	output logic [((SPEED_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [csef_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csef_pkg::CFG_DATA_W-1:0] cfg_data
);

	import csef_pkg::*;

	localparam int SW  = SPEED_WIDTH;
	localparam int MW  = (SW > 33) ? SW : 34;
	localparam int OTW = ((SW + 7) / 8) * 8;

	csef_state_t state_q, state_d;

	logic                use_mag_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                primed_q;

	logic signed [SW-1:0]     vx_q, vy_q;
	logic signed [2*MW-1:0]   prod_q;
	logic [2*SW-1:0]          sqx_q;
	logic signed [MW-1:0]     speed_q;
	logic signed [15:0]       clamp_q;
	logic signed [32:0]       diff_q;
	logic signed [FILT_W-1:0] filter_q;
	logic                     m_tvalid_q;
	logic [SW-1:0]            out_q;

	logic                 s_take;
	logic                 out_free;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [2*MW-1:0] mul_p;
	logic [2*SW-1:0]      radicand;
	logic                 sqrt_start;
	logic                 sqrt_done;
	logic [SW-1:0]        sqrt_root;
	logic [WEIGHT_W-1:0]  alpha;
	logic [LIMIT_W-1:0]   limit_eff;
	logic signed [MW-1:0] lim_pos, lim_neg;
	logic signed [15:0]   clamped;
	logic signed [FILT_W-1:0] target;
	logic signed [2*MW-1:0]   prod_shr;
	logic signed [32:0]       f_new;
	logic signed [32:0]       rnd_sum;
	logic signed [32:0]       rnd_shr;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_take    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = OTW'(out_q);
	assign out_free  = !m_tvalid_q || m_tready;

	assign alpha     = (weight_q > ONE_Q16) ? ONE_Q16 : weight_q;
	assign limit_eff = (limit_q == '0) ? DEFAULT_LIMIT : limit_q;
	assign lim_pos   = MW'($signed({1'b0, limit_eff}));
	assign lim_neg   = -lim_pos;

	always_comb begin
		if (speed_q > lim_pos) begin
			clamped = 16'(lim_pos);
		end else if (speed_q < lim_neg) begin
			clamped = 16'(lim_neg);
		end else begin
			clamped = 16'(speed_q);
		end
	end

	assign target = {clamp_q, 16'h0000};

	// shared multiplier: squares of the velocities, then weight times error
	always_comb begin
		case (state_q)
			ST_SQ_X: begin
				mul_a = MW'(vx_q);
				mul_b = MW'(vx_q);
			end
			ST_SQ_Y: begin
				mul_a = MW'(vy_q);
				mul_b = MW'(vy_q);
			end
			default: begin
				mul_a = MW'(diff_q);
				mul_b = MW'($signed({1'b0, alpha}));
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	assign radicand   = sqx_q + prod_q[2*SW-1:0];
	assign sqrt_start = (state_q == ST_SUM);

	// floor of the q16 product, then add back to the filter
	assign prod_shr = prod_q >>> 16;
	assign f_new    = 33'(filter_q) + prod_shr[32:0];

	// round to nearest, ties upward
	assign rnd_sum = 33'(filter_q) + 33'sd32768;
	assign rnd_shr = rnd_sum >>> 16;

	csef_sqrt_unit #(
		.RW(SW)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(radicand),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_take) begin
					state_d = use_mag_q ? ST_SQ_X : ST_CLAMP;
				end
			end
			ST_SQ_X:   state_d = ST_SQ_Y;
			ST_SQ_Y:   state_d = ST_SUM;
			ST_SUM:    state_d = ST_ROOT;
			ST_ROOT: begin
				if (sqrt_done) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP:  state_d = ST_DIFF;
			ST_DIFF:   state_d = primed_q ? ST_MUL : ST_WRITE;
			ST_MUL:    state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_mag_q <= 1'b0;
			weight_q  <= RESET_WEIGHT;
			limit_q   <= DEFAULT_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_USE_MAGNITUDE:    use_mag_q <= cfg_data[0];
				REG_SMOOTHING_WEIGHT: weight_q  <= cfg_data[WEIGHT_W-1:0];
				REG_SPEED_LIMIT:      limit_q   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q   <= 1'b0;
			filter_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DIFF && !primed_q) begin
				primed_q <= 1'b1;
				filter_q <= target;
			end else if (state_q == ST_UPDATE) begin
				filter_q <= f_new[FILT_W-1:0];
			end
			if (state_q == ST_WRITE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			vx_q    <= s_tdata[SW-1:0];
			vy_q    <= s_tdata[2*SW-1:SW];
			speed_q <= MW'($signed(s_tdata[SW-1:0]));
		end
		case (state_q)
			ST_SQ_X: prod_q <= mul_p;
			ST_SQ_Y: begin
				sqx_q  <= prod_q[2*SW-1:0];
				prod_q <= mul_p;
			end
			ST_ROOT: begin
				if (sqrt_done) begin
					speed_q <= MW'($signed({1'b0, sqrt_root}));
				end
			end
			ST_CLAMP: clamp_q <= clamped;
			ST_DIFF:  diff_q  <= 33'(target) - 33'(filter_q);
			ST_MUL:   prod_q  <= mul_p;
			ST_WRITE: begin
				if (out_free) begin
					out_q <= rnd_shr[SW-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

[src/csef_sqrt_unit.sv]
module csef_sqrt_unit #(
	parameter int RW = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] radicand,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int CW = $clog2(RW + 1);

	logic          active_q;
	logic [CW-1:0] cnt_q;
	logic [2*RW-1:0] n_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;

	logic [RW+2:0] rem_next;
	logic [RW+2:0] trial;
	logic          fits;
	logic [RW+2:0] rem_sub;

	// one result bit per cycle, restoring shift and subtract
	always_comb begin
		rem_next = {rem_q, n_q[2*RW-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		fits     = (rem_next >= trial);
		rem_sub  = rem_next - trial;
	end

	assign done = active_q && (cnt_q == '0);
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			cnt_q    <= CW'(RW);
		end else if (active_q) begin
			if (cnt_q == '0) begin
				active_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (active_q && (cnt_q != '0)) begin
			n_q <= {n_q[2*RW-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sub[RW:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next[RW:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

endmodule
